>>> rtl/core/wfps_pkg.sv
package wfps_pkg;

    // Largest scan the nearest-range search covers; the searched half is half of it.
    localparam int MAX_SCAN_POINTS = 2048;
    localparam logic [11:0] MAX_PTS = 12'(MAX_SCAN_POINTS);

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCAN_POINTS     = 3'd0;
    localparam logic [2:0] CFG_CENTER_INDEX    = 3'd1;
    localparam logic [2:0] CFG_ANGLE_STEP      = 3'd2;
    localparam logic [2:0] CFG_WALL_SETPOINT   = 3'd3;
    localparam logic [2:0] CFG_LOOKAHEAD       = 3'd4;
    localparam logic [2:0] CFG_PROP_GAIN       = 3'd5;
    localparam logic [2:0] CFG_INTEG_GAIN      = 3'd6;
    localparam logic [2:0] CFG_DERIV_GAIN      = 3'd7;

    // Register reset values.
    localparam logic [11:0] RST_SCAN_POINTS     = 12'd1080;
    localparam logic [10:0] RST_CENTER_INDEX    = 11'd270;
    localparam logic [15:0] RST_ANGLE_STEP      = 16'd286;
    localparam logic [15:0] RST_WALL_SETPOINT   = 16'd6144;
    localparam logic [15:0] RST_LOOKAHEAD       = 16'd205;
    localparam logic [15:0] RST_PROP_GAIN       = 16'd6963;
    localparam logic [15:0] RST_INTEG_GAIN      = 16'd33;
    localparam logic [15:0] RST_DERIV_GAIN      = 16'd6554;

    // One over two pi in Q32, and the quarter-wave sine coefficients in Q16.
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [15:0] SIN_C = 16'd4640;
    localparam logic [16:0] SIN_ONE = 17'd65536;

    // Sum of the P, I and D terms, in Q24, at which the steering reaches plus or minus one.
    localparam logic signed [49:0] U_LIMIT = 50'sd16777216;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_PHASE,
        ST_TURN,
        ST_SQUARE,
        ST_POLY_B,
        ST_POLY_A,
        ST_SINE,
        ST_ERROR,
        ST_PTERM,
        ST_ITERM,
        ST_DTERM,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/wall_follow_pid_steering_top.sv
// Wall-following PID steering controller. Range samples of one lidar scan stream in
// on the s_ channel, one transfer per cycle, with s_tlast on the final sample of the
// scan. Over the first half of the scan (at most MAX_SCAN_POINTS/2 samples) the block
// keeps the nearest range and its index. The final sample starts the end-of-scan step:
// wall angle, sine of the angle times lookahead, distance error, saturating integral
// and the P, I and D terms, all worked through one shared 33 by 33 bit signed
// multiplier under a small sequencer. After the final sample s_tready stays low through
// ten multiplier steps, the error step, the final sum step and one output step, longer
// if the previous result has not yet been taken on the m_ channel. Each scan gives
// exactly one result: the steering command, clamped to plus or minus one in Q1.12,
// and the nearest index. Configuration registers are written through cfg_wr_en,
// cfg_index and cfg_wdata and should change only while no scan is in progress.
module wall_follow_pid_steering_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] range_sample
    input  logic        s_tlast,   // last_sample

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [13:0] steering, [24:14] nearest_index, rest zero

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Configuration registers.
    logic [11:0] scan_points_reg;
    logic [10:0] center_index_reg;
    logic [15:0] angle_step_reg;
    logic [15:0] wall_setpoint_reg;
    logic [15:0] lookahead_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;
    logic [15:0] deriv_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_points_reg     <= wfps_pkg::RST_SCAN_POINTS;
            center_index_reg    <= wfps_pkg::RST_CENTER_INDEX;
            angle_step_reg      <= wfps_pkg::RST_ANGLE_STEP;
            wall_setpoint_reg   <= wfps_pkg::RST_WALL_SETPOINT;
            lookahead_reg       <= wfps_pkg::RST_LOOKAHEAD;
            prop_gain_reg       <= wfps_pkg::RST_PROP_GAIN;
            integ_gain_reg      <= wfps_pkg::RST_INTEG_GAIN;
            deriv_gain_reg      <= wfps_pkg::RST_DERIV_GAIN;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wfps_pkg::CFG_SCAN_POINTS:     scan_points_reg     <= cfg_wdata[11:0];
                wfps_pkg::CFG_CENTER_INDEX:    center_index_reg    <= cfg_wdata[10:0];
                wfps_pkg::CFG_ANGLE_STEP:      angle_step_reg      <= cfg_wdata;
                wfps_pkg::CFG_WALL_SETPOINT:   wall_setpoint_reg   <= cfg_wdata;
                wfps_pkg::CFG_LOOKAHEAD:       lookahead_reg       <= cfg_wdata;
                wfps_pkg::CFG_PROP_GAIN:       prop_gain_reg       <= cfg_wdata;
                wfps_pkg::CFG_INTEG_GAIN:      integ_gain_reg      <= cfg_wdata;
                wfps_pkg::CFG_DERIV_GAIN:      deriv_gain_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and scan state.
    wfps_pkg::state_t state_reg, state_next;

    logic [15:0] nearest_range_reg, nearest_range_next;
    logic [10:0] nearest_pos_reg, nearest_pos_next;
    logic [10:0] sample_counter_reg, sample_counter_next;
    logic signed [31:0] error_integral_reg;
    logic signed [17:0] prior_error_reg;

    // Datapath registers.
    logic signed [57:0] prod_reg;
    logic               neg_reg;
    logic               quad_reg;
    logic [16:0]        x_reg;
    logic [16:0]        x2_reg;
    logic               sneg_reg;
    logic signed [17:0] err_reg;
    logic signed [49:0] acc_reg;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [13:0] out_steer_reg;
    logic [10:0] out_index_reg;

    logic s_xfer;
    logic load_out;

    assign s_xfer   = s_tvalid && s_tready;
    assign load_out = (state_reg == wfps_pkg::ST_DONE) && (!m_valid_reg || m_tready);

    // Nearest-range search over the first half of the scan.
    logic [11:0] pts;
    logic [10:0] half;
    logic        take;

    assign pts  = (scan_points_reg > wfps_pkg::MAX_PTS) ? wfps_pkg::MAX_PTS : scan_points_reg;
    assign half = pts[11:1];
    assign take = (sample_counter_reg < half) &&
                  ((sample_counter_reg == 11'd0) || (s_tdata < nearest_range_reg));

    always_comb begin
        nearest_range_next  = nearest_range_reg;
        nearest_pos_next    = nearest_pos_reg;
        sample_counter_next = sample_counter_reg;
        if (s_xfer) begin
            if (take) begin
                nearest_range_next = s_tdata;
                nearest_pos_next   = sample_counter_reg;
            end
            if (sample_counter_reg != 11'h7FF) begin
                sample_counter_next = sample_counter_reg + 11'd1;
            end
        end else if (load_out) begin
            // Rearm for the next scan once the result is handed over.
            nearest_range_next  = 16'hFFFF;
            nearest_pos_next    = 11'd0;
            sample_counter_next = 11'd0;
        end
    end

    // Values taken from the product register at each step.
    logic signed [11:0] diff;
    logic signed [27:0] ang;
    logic [26:0]        ang_mag;
    logic [31:0]        phase_raw;
    logic [31:0]        phase;
    logic [15:0]        frac;
    logic [16:0]        x_val;
    logic [16:0]        x2_val;
    logic [15:0]        t_b;
    logic [16:0]        t_a;
    logic [16:0]        sine_raw;
    logic [16:0]        sine_mag;
    logic [32:0]        sterm_round;
    logic signed [17:0] sterm;
    logic signed [18:0] err_wide;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic signed [18:0] err_delta;

    assign diff      = $signed({1'b0, center_index_reg}) - $signed({1'b0, nearest_pos_reg});
    assign ang       = prod_reg[27:0];
    assign ang_mag   = ang[27] ? 27'(-ang) : ang[26:0];
    assign phase_raw = prod_reg[47:16];
    assign phase     = neg_reg ? (32'd0 - phase_raw) : phase_raw;
    assign frac      = phase[29:14];
    assign x_val     = phase[30] ? (wfps_pkg::SIN_ONE - {1'b0, frac}) : {1'b0, frac};
    assign x2_val    = prod_reg[32:16];
    assign t_b       = wfps_pkg::SIN_B - prod_reg[31:16];
    assign t_a       = wfps_pkg::SIN_A - {1'b0, prod_reg[31:16]};
    assign sine_raw  = prod_reg[32:16];
    assign sine_mag  = (sine_raw > wfps_pkg::SIN_ONE) ? wfps_pkg::SIN_ONE : sine_raw;

    // Sine term rounded half up on its magnitude, then signed.
    assign sterm_round = {1'b0, prod_reg[31:0]} + 33'd32768;
    assign sterm       = sneg_reg ? -$signed({1'b0, sterm_round[32:16]})
                                  :  $signed({1'b0, sterm_round[32:16]});
    assign err_wide    = $signed({3'b000, wall_setpoint_reg})
                       - $signed({3'b000, nearest_range_reg})
                       - {sterm[17], sterm};

    assign integ_sum = {error_integral_reg[31], error_integral_reg}
                     + {{15{err_reg[17]}}, err_reg};
    always_comb begin
        if (integ_sum[32] != integ_sum[31]) begin
            integ_sat = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            integ_sat = integ_sum[31:0];
        end
    end

    assign err_delta = {prior_error_reg[17], prior_error_reg} - {err_reg[17], err_reg};

    // The shared multiplier: operand selection by step.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            wfps_pkg::ST_ANGLE: begin
                mul_a = $signed({17'd0, angle_step_reg});
                mul_b = {{21{diff[11]}}, diff};
            end
            wfps_pkg::ST_PHASE: begin
                mul_a = $signed({6'd0, ang_mag});
                mul_b = $signed({3'd0, wfps_pkg::INV_TWO_PI_Q32});
            end
            wfps_pkg::ST_TURN: begin
                mul_a = $signed({16'd0, x_val});
                mul_b = $signed({16'd0, x_val});
            end
            wfps_pkg::ST_SQUARE: begin
                mul_a = $signed({17'd0, wfps_pkg::SIN_C});
                mul_b = $signed({16'd0, x2_val});
            end
            wfps_pkg::ST_POLY_B: begin
                mul_a = $signed({17'd0, t_b});
                mul_b = $signed({16'd0, x2_reg});
            end
            wfps_pkg::ST_POLY_A: begin
                mul_a = $signed({16'd0, t_a});
                mul_b = $signed({16'd0, x_reg});
            end
            wfps_pkg::ST_SINE: begin
                mul_a = $signed({16'd0, sine_mag});
                mul_b = $signed({17'd0, lookahead_reg});
            end
            wfps_pkg::ST_PTERM: begin
                mul_a = $signed({17'd0, prop_gain_reg});
                mul_b = {{15{err_reg[17]}}, err_reg};
            end
            wfps_pkg::ST_ITERM: begin
                mul_a = $signed({17'd0, integ_gain_reg});
                mul_b = {error_integral_reg[31], error_integral_reg};
            end
            wfps_pkg::ST_DTERM: begin
                mul_a = $signed({17'd0, deriv_gain_reg});
                mul_b = {{14{err_delta[18]}}, err_delta};
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Next step of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wfps_pkg::ST_IDLE:   if (s_xfer && s_tlast) state_next = wfps_pkg::ST_ANGLE;
            wfps_pkg::ST_ANGLE:  state_next = wfps_pkg::ST_PHASE;
            wfps_pkg::ST_PHASE:  state_next = wfps_pkg::ST_TURN;
            wfps_pkg::ST_TURN:   state_next = wfps_pkg::ST_SQUARE;
            wfps_pkg::ST_SQUARE: state_next = wfps_pkg::ST_POLY_B;
            wfps_pkg::ST_POLY_B: state_next = wfps_pkg::ST_POLY_A;
            wfps_pkg::ST_POLY_A: state_next = wfps_pkg::ST_SINE;
            wfps_pkg::ST_SINE:   state_next = wfps_pkg::ST_ERROR;
            wfps_pkg::ST_ERROR:  state_next = wfps_pkg::ST_PTERM;
            wfps_pkg::ST_PTERM:  state_next = wfps_pkg::ST_ITERM;
            wfps_pkg::ST_ITERM:  state_next = wfps_pkg::ST_DTERM;
            wfps_pkg::ST_DTERM:  state_next = wfps_pkg::ST_SUM;
            wfps_pkg::ST_SUM:    state_next = wfps_pkg::ST_DONE;
            wfps_pkg::ST_DONE:   if (load_out) state_next = wfps_pkg::ST_IDLE;
            default:             state_next = wfps_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb begin
        s_tready     = (state_reg == wfps_pkg::ST_IDLE);
        m_valid_next = load_out || (m_valid_reg && !m_tready);
    end

    // Steering: clamp at plus or minus one, otherwise divide by 4096 toward zero.
    logic signed [49:0] u_bias;
    logic signed [49:0] u_shift;
    logic [13:0]        steer;

    assign u_bias  = acc_reg[49] ? (acc_reg + 50'sd4095) : acc_reg;
    assign u_shift = u_bias >>> 12;

    always_comb begin
        if (acc_reg >= wfps_pkg::U_LIMIT) begin
            steer = 14'sd4096;
        end else if (acc_reg <= -wfps_pkg::U_LIMIT) begin
            steer = -14'sd4096;
        end else begin
            steer = u_shift[13:0];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= wfps_pkg::ST_IDLE;
            nearest_range_reg  <= 16'hFFFF;
            nearest_pos_reg    <= 11'd0;
            sample_counter_reg <= 11'd0;
            error_integral_reg <= '0;
            prior_error_reg    <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            nearest_range_reg  <= nearest_range_next;
            nearest_pos_reg    <= nearest_pos_next;
            sample_counter_reg <= sample_counter_next;
            m_valid_reg        <= m_valid_next;
            if (state_reg == wfps_pkg::ST_PTERM) begin
                error_integral_reg <= integ_sat;
            end
            if (state_reg == wfps_pkg::ST_DTERM) begin
                prior_error_reg <= err_reg;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[57:0];
        case (state_reg)
            wfps_pkg::ST_PHASE: neg_reg <= ang[27];
            wfps_pkg::ST_TURN: begin
                quad_reg <= phase[31];
                x_reg    <= x_val;
            end
            wfps_pkg::ST_SQUARE: x2_reg   <= x2_val;
            wfps_pkg::ST_SINE:   sneg_reg <= quad_reg;
            wfps_pkg::ST_ERROR:  err_reg  <= err_wide[17:0];
            wfps_pkg::ST_ITERM:  acc_reg  <= prod_reg[49:0];
            wfps_pkg::ST_DTERM:  acc_reg  <= acc_reg + prod_reg[49:0];
            wfps_pkg::ST_SUM:    acc_reg  <= acc_reg + prod_reg[49:0];
            default: ;
        endcase
        if (load_out) begin
            out_steer_reg <= steer;
            out_index_reg <= nearest_pos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_index_reg, out_steer_reg};

    // The final sample of a scan always blocks the input while the step runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted right after the final sample of a scan");

    // A new result appears only out of the output step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == wfps_pkg::ST_DONE))
        else $error("result raised outside the output step");

    // The steering command never leaves plus or minus one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[13:0]) <= 14'sd4096 &&
                      $signed(m_tdata[13:0]) >= -14'sd4096))
        else $error("steering command outside plus or minus one");

endmodule
